>>> sv/cooler_supervisor_fsm_macros.svh
// assertion macros for the cooler supervisor checker
// used by files that take this header by include; no other dependencies
`ifndef COOLER_SUPERVISOR_FSM_MACROS_SVH
`define COOLER_SUPERVISOR_FSM_MACROS_SVH

// same-cycle implication, held off during reset
`define CS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cooler supervisor check failed");

// next-cycle implication, held off during reset
`define CS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cooler supervisor check failed");

`endif

>>> sv/cs_pkg.sv
// types, codes and helper functions for the cooler supervisor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cs_pkg;

    // item actions
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_FLUSH    = 2'd1;
    localparam logic [1:0] ACT_OVERRIDE = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_STARTUP_TICKS  = 3'd0;
    localparam logic [2:0] CFG_UPDATE_IVL     = 3'd1;
    localparam logic [2:0] CFG_PRESSURE_LIMIT = 3'd2;
    localparam logic [2:0] CFG_FLOW_MIN       = 3'd3;
    localparam logic [2:0] CFG_FLOW_GRACE     = 3'd4;
    localparam logic [2:0] CFG_FLUSH_TIMEOUT  = 3'd5;

    // switch / override positions
    localparam logic [2:0] POS_NONE     = 3'd0;
    localparam logic [2:0] POS_RESET    = 3'd1;
    localparam logic [2:0] POS_PRECHILL = 3'd2;
    localparam logic [2:0] POS_LOW      = 3'd3;
    localparam logic [2:0] POS_MED      = 3'd4;
    localparam logic [2:0] POS_HIGH     = 3'd5;

    // mode codes as seen on the result word
    localparam logic [2:0] MC_STARTUP  = 3'd0;
    localparam logic [2:0] MC_RESET    = 3'd1;
    localparam logic [2:0] MC_REQRESET = 3'd2;
    localparam logic [2:0] MC_FLUSH    = 3'd3;
    localparam logic [2:0] MC_PRECHILL = 3'd4;
    localparam logic [2:0] MC_LOW      = 3'd5;
    localparam logic [2:0] MC_MED      = 3'd6;
    localparam logic [2:0] MC_HIGH     = 3'd7;

    // fault bit positions
    localparam int F_STARTUP  = 0;
    localparam int F_COOLANT  = 1;
    localparam int F_FLOW     = 2;
    localparam int F_PRESSURE = 3;
    localparam int F_UNDERV   = 4;
    localparam int F_OVERV    = 5;
    localparam int F_COMP     = 6;

    localparam logic [3:0] BLINK_NONE  = 4'd0;
    localparam logic [3:0] BLINK_COMP  = 4'd6;
    localparam logic [3:0] BLINK_OTHER = 4'd14;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MED  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    localparam logic [15:0] START_MAX   = 16'hFFFF;
    localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;

    typedef enum logic [7:0] {
        MODE_STARTUP  = 8'b0000_0001,
        MODE_RESET    = 8'b0000_0010,
        MODE_REQRESET = 8'b0000_0100,
        MODE_FLUSH    = 8'b0000_1000,
        MODE_PRECHILL = 8'b0001_0000,
        MODE_LOW      = 8'b0010_0000,
        MODE_MED      = 8'b0100_0000,
        MODE_HIGH     = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] pressure_kpa;
        logic        coolant_ok;
        logic [2:0]  compressor_code;
        logic        over_voltage;
        logic        low_supply;
        logic        pump_running;
        logic [15:0] pump_run_ms;
        logic [15:0] flow_rate;
        logic [2:0]  switch_position;
        logic [2:0]  override_position;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] fault_flags;
        logic [3:0] blink_code;
        logic [2:0] latched_code;
        logic       update_done;
        logic       enable_request;
        logic       shirt_pump_on;
        logic [1:0] temp_band;
    } result_t;

    typedef struct packed {
        logic [15:0] startup_ticks;
        logic [15:0] update_interval;
        logic [15:0] pressure_limit_kpa;
        logic [15:0] flow_min;
        logic [15:0] flow_grace_ms;
        logic [19:0] flush_max_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  fault;
        logic [2:0]  code;
        logic [15:0] startup_count;
        logic [15:0] interval_count;
        logic        flush_pending;
        logic [19:0] flush_elapsed;
        logic [2:0]  override_pos;
    } state_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] c;
        c = MC_STARTUP;
        unique case (m)
            MODE_STARTUP:  c = MC_STARTUP;
            MODE_RESET:    c = MC_RESET;
            MODE_REQRESET: c = MC_REQRESET;
            MODE_FLUSH:    c = MC_FLUSH;
            MODE_PRECHILL: c = MC_PRECHILL;
            MODE_LOW:      c = MC_LOW;
            MODE_MED:      c = MC_MED;
            MODE_HIGH:     c = MC_HIGH;
            default:       c = MC_STARTUP;
        endcase
        return c;
    endfunction

    // first set fault wins; compressor fault reports its captured code
    function automatic logic [3:0] blink_of(input logic [6:0] f, input logic [2:0] code);
        logic [3:0] b;
        if (f[F_STARTUP])
            b = 4'd1;
        else if (f[F_COOLANT])
            b = 4'd2;
        else if (f[F_FLOW])
            b = 4'd3;
        else if (f[F_PRESSURE])
            b = 4'd4;
        else if (f[F_UNDERV])
            b = 4'd5;
        else if (f[F_OVERV])
            b = 4'd6;
        else if (f[F_COMP] && code != 3'd0)
            b = BLINK_COMP + {1'b0, code};
        else if (f != 7'd0)
            b = BLINK_OTHER;
        else
            b = BLINK_NONE;
        return b;
    endfunction

endpackage

`default_nettype wire

>>> sv/cooler_supervisor_fsm.sv
// an accepted item passes the item register and step logic into the result register;
// throughput: one item per clock if not stalled, limited by the single step stage between
// them; the item side stalls only while both are full and the result side stalls.
// reset: asynchronous, active low; clears mode, faults, counters, override and the
// configuration registers to their defaults; no clearing pass, items taken at once
`timescale 1ns / 1ps
`default_nettype none

module cooler_supervisor_fsm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire cs_pkg::item_t   item,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output cs_pkg::result_t      result,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [19:0]     cfg_data
);

    cs_pkg::item_t   item_reg;
    logic            item_valid_reg;
    cs_pkg::result_t result_reg;
    logic            result_valid_reg;
    cs_pkg::state_t  st_reg;
    cs_pkg::state_t  st_next;
    cs_pkg::cfg_t    cfg_reg;
    cs_pkg::result_t res_next;
    logic            advance;
    logic            take;

    // item moves on when the result register is empty or being drained
    assign advance      = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = item_valid_reg && !(!result_valid_reg || !result_stall);
    assign take         = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    cs_step u_step (
        .item    (item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
        if (advance)
            result_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode           <= cs_pkg::MODE_STARTUP;
            st_reg.fault          <= '0;
            st_reg.code           <= '0;
            st_reg.startup_count  <= '0;
            st_reg.interval_count <= '0;
            st_reg.flush_pending  <= 1'b0;
            st_reg.flush_elapsed  <= '0;
            st_reg.override_pos   <= cs_pkg::POS_NONE;
        end
        else if (advance)
            st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.startup_ticks      <= 16'd1000;
            cfg_reg.update_interval    <= 16'd100;
            cfg_reg.pressure_limit_kpa <= 16'd2000;
            cfg_reg.flow_min           <= 16'd500;
            cfg_reg.flow_grace_ms      <= 16'd5000;
            cfg_reg.flush_max_ticks    <= 20'd60000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cs_pkg::CFG_STARTUP_TICKS:  cfg_reg.startup_ticks      <= cfg_data[15:0];
                cs_pkg::CFG_UPDATE_IVL:     cfg_reg.update_interval    <= cfg_data[15:0];
                cs_pkg::CFG_PRESSURE_LIMIT: cfg_reg.pressure_limit_kpa <= cfg_data[15:0];
                cs_pkg::CFG_FLOW_MIN:       cfg_reg.flow_min           <= cfg_data[15:0];
                cs_pkg::CFG_FLOW_GRACE:     cfg_reg.flow_grace_ms      <= cfg_data[15:0];
                cs_pkg::CFG_FLUSH_TIMEOUT:  cfg_reg.flush_max_ticks    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/cs_step.sv
// next-state and result logic for one item of the cooler supervisor
// depends on cs_pkg
`timescale 1ns / 1ps
`default_nettype none

module cs_step (
    input  wire cs_pkg::item_t  item,
    input  wire cs_pkg::cfg_t   cfg,
    input  wire cs_pkg::state_t st,
    output cs_pkg::state_t      st_next,
    output cs_pkg::result_t     res
);

    cs_pkg::state_t s;
    logic           done;
    logic           go;
    logic [2:0]     pos;

    always_comb
    begin
        s    = st;
        done = 1'b0;
        go   = 1'b1;
        pos  = (st.override_pos != cs_pkg::POS_NONE) ? st.override_pos : item.switch_position;

        unique case (item.action)
            cs_pkg::ACT_FLUSH:
            begin
                s.flush_pending = (st.mode != cs_pkg::MODE_FLUSH);
            end
            cs_pkg::ACT_OVERRIDE:
            begin
                s.override_pos = (st.override_pos == item.override_position) ?
                                 cs_pkg::POS_NONE : item.override_position;
            end
            cs_pkg::ACT_TICK:
            begin
                if (s.startup_count != cs_pkg::START_MAX)
                    s.startup_count = s.startup_count + 16'd1;
                if (s.mode == cs_pkg::MODE_FLUSH && s.flush_elapsed != cs_pkg::ELAPSED_MAX)
                    s.flush_elapsed = s.flush_elapsed + 20'd1;

                if (s.mode == cs_pkg::MODE_STARTUP)
                begin
                    if (s.startup_count < cfg.startup_ticks)
                        go = 1'b0;
                    else
                    begin
                        s.interval_count              = '0;
                        s.fault[cs_pkg::F_STARTUP]    = 1'b1;
                    end
                end

                if (go)
                begin
                    if (s.interval_count == '0)
                    begin
                        // zero interval behaves as one: update on every tick
                        s.interval_count = (cfg.update_interval == '0) ?
                                           '0 : cfg.update_interval - 16'd1;
                        done   = 1'b1;
                        s.code = item.compressor_code;
                        if (item.pressure_kpa >= cfg.pressure_limit_kpa)
                            s.fault[cs_pkg::F_PRESSURE] = 1'b1;
                        if (!item.coolant_ok)
                            s.fault[cs_pkg::F_COOLANT] = 1'b1;
                        if (item.compressor_code != 3'd0)
                            s.fault[cs_pkg::F_COMP] = 1'b1;
                        if (item.over_voltage)
                            s.fault[cs_pkg::F_OVERV] = 1'b1;
                        if (item.low_supply)
                            s.fault[cs_pkg::F_UNDERV] = 1'b1;
                        if (item.pump_running && item.flow_rate < cfg.flow_min &&
                            item.pump_run_ms >= cfg.flow_grace_ms)
                            s.fault[cs_pkg::F_FLOW] = 1'b1;

                        if (s.mode != cs_pkg::MODE_FLUSH && s.flush_pending)
                        begin
                            s.mode          = cs_pkg::MODE_FLUSH;
                            s.flush_elapsed = '0;
                        end
                        else if (!(s.mode == cs_pkg::MODE_FLUSH && s.flush_pending &&
                                   s.flush_elapsed < cfg.flush_max_ticks))
                        begin
                            // not flushing, or flush over: a finished flush is marked like a fresh start-up
                            if (s.mode == cs_pkg::MODE_FLUSH)
                            begin
                                s.fault[cs_pkg::F_STARTUP] = 1'b1;
                                s.flush_pending            = 1'b0;
                            end
                            if (s.fault != 7'd0)
                                s.mode = cs_pkg::MODE_REQRESET;
                            if (pos == cs_pkg::POS_RESET)
                            begin
                                s.fault = '0;
                                s.code  = '0;
                                s.mode  = cs_pkg::MODE_RESET;
                            end
                            else if (s.mode != cs_pkg::MODE_REQRESET)
                            begin
                                case (pos)
                                    cs_pkg::POS_PRECHILL: s.mode = cs_pkg::MODE_PRECHILL;
                                    cs_pkg::POS_LOW:      s.mode = cs_pkg::MODE_LOW;
                                    cs_pkg::POS_MED:      s.mode = cs_pkg::MODE_MED;
                                    cs_pkg::POS_HIGH:     s.mode = cs_pkg::MODE_HIGH;
                                    default:              ;
                                endcase
                            end
                        end
                    end
                    else
                        s.interval_count = s.interval_count - 16'd1;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st_next            = s;
        res.mode           = cs_pkg::mode_code(s.mode);
        res.fault_flags    = s.fault;
        res.blink_code     = cs_pkg::blink_of(s.fault, s.code);
        res.latched_code   = s.code;
        res.update_done    = done;
        res.enable_request = 1'b0;
        res.shirt_pump_on  = 1'b0;
        res.temp_band      = cs_pkg::BAND_HIGH;
        unique case (s.mode) inside
            cs_pkg::MODE_PRECHILL:
            begin
                res.enable_request = 1'b1;
                res.temp_band      = cs_pkg::BAND_MED;
            end
            cs_pkg::MODE_LOW:
            begin
                res.enable_request = 1'b1;
                res.shirt_pump_on  = 1'b1;
                res.temp_band      = cs_pkg::BAND_LOW;
            end
            cs_pkg::MODE_MED:
            begin
                res.enable_request = 1'b1;
                res.shirt_pump_on  = 1'b1;
                res.temp_band      = cs_pkg::BAND_MED;
            end
            cs_pkg::MODE_HIGH:
            begin
                res.enable_request = 1'b1;
                res.shirt_pump_on  = 1'b1;
            end
            cs_pkg::MODE_FLUSH:
            begin
                res.shirt_pump_on = 1'b1;
            end
            cs_pkg::MODE_STARTUP, cs_pkg::MODE_RESET, cs_pkg::MODE_REQRESET: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/cs_checker.sv
// port-level checks for the cooler supervisor, bound to the top level
// depends on cs_pkg and cooler_supervisor_fsm_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "cooler_supervisor_fsm_macros.svh"

module cs_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            result_valid,
    input wire logic            result_stall,
    input wire cs_pkg::result_t result
);

    logic in_reqreset;
    logic in_startup;
    logic no_fault;
    logic no_blink;
    logic upd_word;

    assign in_reqreset = result_valid && (result.mode == cs_pkg::MC_REQRESET);
    assign in_startup  = (result.mode == cs_pkg::MC_STARTUP);
    assign no_fault    = (result.fault_flags == 7'd0);
    assign no_blink    = (result.blink_code == cs_pkg::BLINK_NONE);
    assign upd_word    = result_valid && result.update_done;

    // requires-reset is only entered with a fault latched, and only reset clears faults
    `CS_ASSERT_NOW(a_reqreset_has_fault, clk, rst_n, in_reqreset, !no_fault)

    // blink code is zero exactly when no fault is latched
    `CS_ASSERT_NOW(a_blink_matches_faults, clk, rst_n, result_valid, no_blink == no_fault)

    // an update always leaves start-up behind
    `CS_ASSERT_NOW(a_update_leaves_startup, clk, rst_n, upd_word, !in_startup)

    // a stalled result word holds
    `CS_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind cooler_supervisor_fsm cs_checker u_cs_checker (.*);

`default_nettype wire
